@@ rtl/assert_macros.svh @@
// Assertion helpers used by ljms_core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define LJMS_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("ljms assertion failed");
`define LJMS_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("ljms forbidden condition seen");
`else
`define LJMS_ASSERT(lbl, clk, rst_n, prop)
`define LJMS_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ rtl/ljms_pkg.sv @@
package ljms_pkg;

    typedef enum logic [2:0] {
        MODE_RELAX     = 3'd0,
        MODE_NORMAL    = 3'd1,
        MODE_OFFGROUND = 3'd2,
        MODE_SPIN      = 3'd3,
        MODE_JUMP      = 3'd4
    } mode_t;

    typedef enum logic [2:0] {
        PH_NONE    = 3'd0,
        PH_START   = 3'd1,
        PH_EXTEND  = 3'd2,
        PH_AIR     = 3'd3,
        PH_LANDING = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        CMD_RELAX  = 2'd0,
        CMD_NORMAL = 2'd1,
        CMD_SPIN   = 2'd2,
        CMD_JUMP   = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        SRC_ZERO    = 3'd0,
        SRC_LENGTH  = 3'd1,
        SRC_EXTEND  = 3'd2,
        SRC_RETRACT = 3'd3,
        SRC_LANDING = 3'd4
    } source_t;

    localparam logic [1:0] JC_NONE     = 2'd0;
    localparam logic [1:0] JC_PREPARED = 2'd1;
    localparam logic [1:0] JC_JUMP     = 2'd2;

    typedef enum logic [2:0] {
        REG_SUPPORT_FORCE_LIMIT   = 3'd0,
        REG_EXTEND_DONE_LENGTH    = 3'd1,
        REG_RETRACT_DONE_LENGTH   = 3'd2,
        REG_LANDING_LENGTH        = 3'd3,
        REG_LANDING_SAG           = 3'd4,
        REG_LANDING_RATE_LIMIT    = 3'd5,
        REG_TOUCHDOWN_TICKS       = 3'd6
    } reg_idx_t;

    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;

    localparam logic [15:0] RST_SUPPORT_FORCE_LIMIT   = 16'd200;
    localparam logic [13:0] RST_EXTEND_DONE_LENGTH    = 14'd3500;
    localparam logic [13:0] RST_RETRACT_DONE_LENGTH   = 14'd1500;
    localparam logic [13:0] RST_LANDING_LENGTH        = 14'd2000;
    localparam logic [13:0] RST_LANDING_SAG           = 14'd200;
    localparam logic [14:0] RST_LANDING_RATE_LIMIT    = 15'd100;
    localparam logic [7:0]  RST_TOUCHDOWN_TICKS       = 8'd5;

    typedef struct packed {
        logic [15:0] support_force_limit;
        logic [13:0] extend_done_length;
        logic [13:0] retract_done_length;
        logic [13:0] landing_length;
        logic [13:0] landing_sag;
        logic [14:0] landing_rate_limit;
        logic [7:0]  touchdown_ticks;
    } cfg_t;

    typedef struct packed {
        logic               link_ok;
        logic [1:0]         mode_command;
        logic [1:0]         jump_request;
        logic [13:0]        left_length;
        logic [13:0]        right_length;
        logic signed [15:0] left_length_rate;
        logic signed [15:0] right_length_rate;
        logic signed [15:0] left_support;
        logic signed [15:0] right_support;
    } item_t;

    typedef struct packed {
        logic [2:0] chassis_mode;
        logic [2:0] jump_phase;
        logic [2:0] force_source;
        logic       offground_balance;
        logic       relax_flag;
        logic       odom_reset;
        logic       clear_roll_loop;
        logic       clear_retract_loop;
    } result_t;

endpackage

@@ rtl/ljms_if.sv @@
interface ljms_item_if;
    import ljms_pkg::*;

    logic  valid;
    logic  ready;
    item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface ljms_result_if;
    import ljms_pkg::*;

    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ljms_cfg.sv @@
module ljms_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ljms_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ljms_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ljms_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output ljms_pkg::cfg_t                      cfg
);
    import ljms_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_SUPPORT_FORCE_LIMIT:   cfg_next.support_force_limit   = pwdata[15:0];
                REG_EXTEND_DONE_LENGTH:    cfg_next.extend_done_length    = pwdata[13:0];
                REG_RETRACT_DONE_LENGTH:   cfg_next.retract_done_length   = pwdata[13:0];
                REG_LANDING_LENGTH:        cfg_next.landing_length        = pwdata[13:0];
                REG_LANDING_SAG:           cfg_next.landing_sag           = pwdata[13:0];
                REG_LANDING_RATE_LIMIT:    cfg_next.landing_rate_limit    = pwdata[14:0];
                REG_TOUCHDOWN_TICKS:       cfg_next.touchdown_ticks       = pwdata[7:0];
                default:                   cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        unique case (idx)
            REG_SUPPORT_FORCE_LIMIT:   prdata[15:0] = cfg_reg.support_force_limit;
            REG_EXTEND_DONE_LENGTH:    prdata[13:0] = cfg_reg.extend_done_length;
            REG_RETRACT_DONE_LENGTH:   prdata[13:0] = cfg_reg.retract_done_length;
            REG_LANDING_LENGTH:        prdata[13:0] = cfg_reg.landing_length;
            REG_LANDING_SAG:           prdata[13:0] = cfg_reg.landing_sag;
            REG_LANDING_RATE_LIMIT:    prdata[14:0] = cfg_reg.landing_rate_limit;
            REG_TOUCHDOWN_TICKS:       prdata[7:0]  = cfg_reg.touchdown_ticks;
            default:                   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.support_force_limit   <= RST_SUPPORT_FORCE_LIMIT;
            cfg_reg.extend_done_length    <= RST_EXTEND_DONE_LENGTH;
            cfg_reg.retract_done_length   <= RST_RETRACT_DONE_LENGTH;
            cfg_reg.landing_length        <= RST_LANDING_LENGTH;
            cfg_reg.landing_sag           <= RST_LANDING_SAG;
            cfg_reg.landing_rate_limit    <= RST_LANDING_RATE_LIMIT;
            cfg_reg.touchdown_ticks       <= RST_TOUCHDOWN_TICKS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

@@ rtl/ljms_core.sv @@
`include "assert_macros.svh"

module ljms_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  ljms_pkg::item_t   item,
    input  ljms_pkg::cfg_t    cfg,
    output ljms_pkg::result_t res
);
    import ljms_pkg::*;

    typedef struct packed {
        mode_t  mode;
        phase_t phase;
    } norm_t;

    // Normal-mode rules: spin request, jump preparation and launch.
    function automatic norm_t norm_step(cmd_t cmd, logic [1:0] jc, mode_t m, phase_t p);
        norm_t r;
        r.mode  = m;
        r.phase = p;
        if (cmd == CMD_SPIN)
        begin
            r.mode = MODE_SPIN;
        end
        if (cmd == CMD_JUMP)
        begin
            if (jc == JC_PREPARED)
            begin
                r.phase = PH_START;
            end
            else if (jc == JC_JUMP && p == PH_START)
            begin
                r.phase = PH_EXTEND;
                r.mode  = MODE_JUMP;
            end
        end
        else
        begin
            r.phase = PH_NONE;
        end
        return r;
    endfunction

    mode_t        mode_reg, mode_next;
    phase_t       phase_reg, phase_next;
    logic [7:0]   cnt_reg, cnt_next, cnt_calc, cnt_inc, cnt_land;

    cmd_t         cmd;
    logic [1:0]   jc;
    logic [14:0]  lsum;
    logic [16:0]  rate_sum;
    logic [16:0]  sup_sum;
    logic [14:0]  land_diff;
    logic         offground, extend_done, retract_done;
    logic         compressed, compressing, confirmed, jump_active;
    norm_t        normal, fallback;
    source_t      source;
    logic         offbal, relax, odom, clr_roll, clr_ret;

    assign cmd = cmd_t'(item.mode_command);
    assign jc  = item.jump_request;

    always_comb
    begin
        lsum      = {1'b0, item.left_length} + {1'b0, item.right_length};
        rate_sum  = {item.left_length_rate[15], item.left_length_rate}
                  + {item.right_length_rate[15], item.right_length_rate};
        sup_sum   = {item.left_support[15], item.left_support}
                  + {item.right_support[15], item.right_support};
        land_diff = {1'b0, cfg.landing_length} - {1'b0, cfg.landing_sag};

        offground    = $signed({sup_sum[16], sup_sum})
                     < $signed({2'b00, cfg.support_force_limit});
        extend_done  = lsum > {cfg.extend_done_length, 1'b0};
        retract_done = lsum < {cfg.retract_done_length, 1'b0};
        compressed   = $signed({2'b00, lsum}) < $signed({land_diff[14], land_diff, 1'b0});
        compressing  = $signed({rate_sum[16], rate_sum})
                     < -$signed({2'b00, cfg.landing_rate_limit, 1'b0});

        cnt_inc   = (cnt_reg == 8'hFF) ? cnt_reg : cnt_reg + 8'd1;
        cnt_land  = (compressed && compressing) ? cnt_inc : 8'd0;
        confirmed = cnt_land >= cfg.touchdown_ticks;

        jump_active = cmd == CMD_JUMP && jc == JC_JUMP
                   && (phase_reg == PH_EXTEND || phase_reg == PH_AIR
                       || phase_reg == PH_LANDING);

        normal   = norm_step(cmd, jc, mode_reg, phase_reg);
        fallback = norm_step(cmd, jc, MODE_NORMAL, PH_NONE);

        mode_next  = mode_reg;
        phase_next = phase_reg;
        cnt_calc   = cnt_reg;
        source     = SRC_ZERO;
        offbal     = 1'b0;
        relax      = 1'b0;
        odom       = 1'b0;
        clr_roll   = 1'b0;
        clr_ret    = 1'b0;

        if (!item.link_ok || cmd == CMD_RELAX)
        begin
            clr_roll   = mode_reg != MODE_RELAX;
            mode_next  = MODE_RELAX;
            phase_next = PH_NONE;
            relax      = 1'b1;
            odom       = 1'b1;
        end
        else
        begin
            unique case (mode_reg)
                MODE_RELAX:
                begin
                    relax = 1'b1;
                    odom  = 1'b1;
                    if (cmd == CMD_NORMAL || cmd == CMD_JUMP)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                    else if (cmd == CMD_SPIN)
                    begin
                        mode_next = MODE_SPIN;
                    end
                end
                MODE_NORMAL:
                begin
                    source     = SRC_LENGTH;
                    mode_next  = normal.mode;
                    phase_next = normal.phase;
                end
                MODE_SPIN:
                begin
                    source     = SRC_LENGTH;
                    mode_next  = normal.mode;
                    phase_next = normal.phase;
                    if (normal.mode == MODE_SPIN && cmd != CMD_SPIN)
                    begin
                        mode_next = MODE_NORMAL;
                    end
                end
                MODE_JUMP:
                begin
                    if (!jump_active)
                    begin
                        source     = SRC_LENGTH;
                        mode_next  = fallback.mode;
                        phase_next = fallback.phase;
                    end
                    else if (phase_reg == PH_EXTEND)
                    begin
                        source = SRC_EXTEND;
                        offbal = offground;
                        if (extend_done)
                        begin
                            phase_next = PH_AIR;
                            clr_ret    = 1'b1;
                        end
                    end
                    else if (phase_reg == PH_AIR)
                    begin
                        source = SRC_RETRACT;
                        offbal = 1'b1;
                        odom   = 1'b1;
                        if (retract_done)
                        begin
                            phase_next = PH_LANDING;
                        end
                    end
                    else
                    begin
                        source   = SRC_LANDING;
                        offbal   = 1'b1;
                        odom     = 1'b1;
                        cnt_calc = cnt_land;
                        if (confirmed)
                        begin
                            phase_next = PH_NONE;
                            mode_next  = MODE_NORMAL;
                        end
                    end
                end
                default:
                begin
                    relax = 1'b1;
                end
            endcase
        end

        // any stage change restarts touchdown confirmation
        cnt_next = (phase_next != phase_reg) ? 8'd0 : cnt_calc;
    end

    assign res.chassis_mode       = mode_next;
    assign res.jump_phase         = phase_next;
    assign res.force_source       = source;
    assign res.offground_balance  = offbal;
    assign res.relax_flag         = relax;
    assign res.odom_reset         = odom;
    assign res.clear_roll_loop    = clr_roll;
    assign res.clear_retract_loop = clr_ret;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_RELAX;
            phase_reg <= PH_NONE;
            cnt_reg   <= 8'd0;
        end
        else if (step_en)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    `LJMS_ASSERT(a_cnt_only_landing, clk, rst_n, (cnt_reg != 8'd0) |-> (phase_reg == PH_LANDING))
    `LJMS_ASSERT(a_jump_has_stage, clk, rst_n, (mode_reg == MODE_JUMP) |-> (phase_reg == PH_EXTEND || phase_reg == PH_AIR || phase_reg == PH_LANDING))
    `LJMS_ASSERT_NEVER(a_relax_no_stage, clk, rst_n, mode_reg == MODE_RELAX && phase_reg != PH_NONE)
    `LJMS_ASSERT(a_clr_ret_enters_air, clk, rst_n, (step_en && res.clear_retract_loop) |=> (phase_reg == PH_AIR))

endmodule

@@ rtl/leg_jump_mode_sequencer.sv @@
// channel  | dir | handshake      | transaction
// ---------+-----+----------------+----------------------------------------
// item     | in  | valid / ready  | one control tick: commands, legs, forces
// result   | out | valid / ready  | mode, stage, force source and flags
// apb      | in  | psel / penable | config register write or read
//
// One transaction per clock cycle sustained while result.ready is high; an accepted
// item passes through the input register, then step logic into the result register.
// Reset (rst_n low) returns mode to relax, stage to none, clears the
// touchdown counter and loads config defaults.
// With result.ready low the result register holds and one more item can wait
// in the input register before item.ready drops.
module leg_jump_mode_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    ljms_item_if.sink                           item,
    ljms_result_if.source                       result,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ljms_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ljms_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ljms_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);
    import ljms_pkg::*;

    cfg_t    cfg;
    logic    in_valid_reg, in_valid_next;
    item_t   in_data_reg;
    logic    out_valid_reg, out_valid_next;
    result_t out_data_reg;
    result_t step_res;
    logic    out_free, step_en, item_take;

    assign out_free   = !out_valid_reg || result.ready;
    assign step_en    = in_valid_reg && out_free;
    assign item.ready = !in_valid_reg || out_free;
    assign item_take  = item.valid && item.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (step_en)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            in_data_reg <= item.data;
        end
        if (step_en)
        begin
            out_data_reg <= step_res;
        end
    end

    ljms_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    ljms_core u_core (
        .clk     (clk),
        .rst_n   (rst_n),
        .step_en (step_en),
        .item    (in_data_reg),
        .cfg     (cfg),
        .res     (step_res)
    );

endmodule
